/* src/assert_macros.svh */
// Assertion macros shared by the sequencer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition on every rising clock edge outside reset
`define CCDSEQ_ASSERT(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// check that an antecedent implies a consequent in the same cycle
`define CCDSEQ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// check that an antecedent implies a consequent in the cycle after it
`define CCDSEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/ccdseq_pkg.sv */
// Types, codes and constants of the CCD clock sequencer
package ccdseq_pkg;

  localparam int BIN_W           = 5;
  localparam int PIX_W           = 15;
  localparam int CNT_W           = 6;
  localparam int MAX_BINNING_DEF = 16;
  localparam int LINE_LEN        = 40;
  localparam int LINE_GROUP      = 8;

  localparam logic [BIN_W-1:0]  BINNING_RESET = BIN_W'(1);
  localparam logic [15:0]       PIX_FLIP      = 16'h8888;
  localparam logic [PIX_W-1:0]  PIX_MAX       = 15'd32767;
  localparam logic [7:0]        CTL_FLIP      = 8'd5;

  localparam logic [7:0] BYTE_247 = 8'd247;
  localparam logic [7:0] BYTE_255 = 8'd255;
  localparam logic [7:0] BYTE_239 = 8'd239;
  localparam logic [7:0] BYTE_251 = 8'hfb;
  localparam logic [7:0] BYTE_250 = 8'hfa;
  localparam logic [7:0] BYTE_249 = 8'hf9;
  localparam logic [7:0] BYTE_247F = 8'hf7;
  localparam logic [7:0] BYTE_219 = 8'd219;
  localparam logic [7:0] BYTE_91  = 8'd91;
  localparam logic [7:0] BYTE_155 = 8'd155;
  localparam logic [7:0] BYTE_27  = 8'd27;

  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_PRE   = CNT_W'(5);
  localparam logic [CNT_W-1:0] CNT_TAIL  = CNT_W'(4);
  localparam logic [CNT_W-1:0] CNT_CLAMP = CNT_W'(6);
  localparam logic [CNT_W-1:0] CNT_LINE  = CNT_W'(LINE_LEN);
  localparam logic [CNT_W-1:0] LINE_B1   = CNT_W'(4 * LINE_GROUP);
  localparam logic [CNT_W-1:0] LINE_B2   = CNT_W'(3 * LINE_GROUP);
  localparam logic [CNT_W-1:0] LINE_B3   = CNT_W'(2 * LINE_GROUP);
  localparam logic [CNT_W-1:0] LINE_B4   = CNT_W'(LINE_GROUP);

  typedef enum logic [1:0] {
    KIND_DIGITIZE = 2'd0,
    KIND_LINE     = 2'd1,
    KIND_FAST     = 2'd2,
    KIND_CONTROL  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_D247,
    S_D255,
    S_D239,
    S_DBHI,
    S_DBLO,
    S_D251,
    S_D219,
    S_D91,
    S_D155,
    S_D27,
    S_LINE,
    S_F7,
    S_FF,
    S_FB,
    S_CTL
  } state_t;

  typedef enum logic [3:0] {
    BS_247,
    BS_255,
    BS_239,
    BS_251,
    BS_219,
    BS_91,
    BS_155,
    BS_27,
    BS_LINE,
    BS_F7,
    BS_CTL
  } byte_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_DEC,
    CNT_LOAD,
    CNT_LOAD_BIN
  } cnt_op_t;

  typedef struct packed {
    logic             load;
    cnt_op_t          cnt_op;
    logic [CNT_W-1:0] cnt_value;
    logic             emit;
    byte_sel_t        sel;
    logic             last;
    logic             pix;
  } ctl_t;

  typedef struct packed {
    logic adv;
    logic cnt_last;
    logic bin_zero;
  } stat_t;

endpackage

/* src/ccdseq_cmd_if.sv */
// Request channel of the CCD clock sequencer
interface ccdseq_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] adc_status_a;
  logic [7:0] adc_status_b;
  logic [7:0] adc_status_c;
  logic [7:0] adc_status_d;
  logic [7:0] control_value;
  logic       end_of_row;

  modport source (
    output valid, kind, adc_status_a, adc_status_b, adc_status_c, adc_status_d,
           control_value, end_of_row,
    input  ready
  );
  modport sink (
    input  valid, kind, adc_status_a, adc_status_b, adc_status_c, adc_status_d,
           control_value, end_of_row,
    output ready
  );
endinterface

/* src/ccdseq_res_if.sv */
// Result channel of the CCD clock sequencer
interface ccdseq_res_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  drive_byte;
  logic                        to_control_port;
  logic                        pixel_valid;
  logic [ccdseq_pkg::PIX_W-1:0] pixel_value;
  logic                        row_done;
  logic                        last;

  modport source (
    output valid, drive_byte, to_control_port, pixel_valid, pixel_value, row_done, last,
    input  ready
  );
  modport sink (
    input  valid, drive_byte, to_control_port, pixel_valid, pixel_value, row_done, last,
    output ready
  );
endinterface

/* src/ccd_clock_sequencer.sv */
// Top level of the CCD clock sequencer
// Each request is one command and comes back as a run of drive bytes, one result per byte,
// the last one flagged by last (with row_done echoing end_of_row, and for a digitize the
// pixel sample on pixel_valid/pixel_value). Run lengths: digitize 20 + 2 * binning bytes
// (binning capped at MAX_BINNING, so 52 at 16), line load 40, fast shift 3, control write 1.
// The sequencer emits one byte per clock into its single result register while results are
// taken at once; a stalled result holds the sequencer. A new request is taken once the
// previous run's last byte sits in the result register. Write binning only between runs.
`include "assert_macros.svh"

module ccd_clock_sequencer #(
  parameter int MAX_BINNING = ccdseq_pkg::MAX_BINNING_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [ccdseq_pkg::BIN_W-1:0] cfg_data,
  ccdseq_cmd_if.sink                   cmd,
  ccdseq_res_if.source                 res
);

  ccdseq_pkg::ctl_t  ctl;
  ccdseq_pkg::stat_t stat;

  ccdseq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_kind  (cmd.kind),
    .cmd_ready (cmd.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  ccdseq_dp #(
    .MAX_BINNING (MAX_BINNING)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .ctl      (ctl),
    .stat     (stat),
    .cmd      (cmd),
    .res      (res)
  );

  `CCDSEQ_ASSERT_IMP(a_pix_on_last, clk, rst, res.valid && res.pixel_valid, res.last)
  `CCDSEQ_ASSERT_IMP(a_ctl_on_last, clk, rst, res.valid && res.to_control_port, res.last)
  `CCDSEQ_ASSERT_IMP(a_row_on_last, clk, rst, res.valid && res.row_done, res.last)
  `CCDSEQ_ASSERT_NEXT(a_busy_after_take, clk, rst, cmd.valid && cmd.ready, !cmd.ready)

endmodule

/* src/ccdseq_ctrl.sv */
// Waveform state machine of the CCD clock sequencer
module ccdseq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  logic [1:0]          cmd_kind,
  output logic                cmd_ready,
  input  ccdseq_pkg::stat_t   stat,
  output ccdseq_pkg::ctl_t    ctl
);

  ccdseq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ccdseq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd_ready     = 1'b0;
    ctl.load      = 1'b0;
    ctl.cnt_op    = ccdseq_pkg::CNT_HOLD;
    ctl.cnt_value = '0;
    ctl.emit      = 1'b0;
    ctl.sel       = ccdseq_pkg::BS_247;
    ctl.last      = 1'b0;
    ctl.pix       = 1'b0;
    if (state == ccdseq_pkg::S_IDLE) begin
      cmd_ready = 1'b1;
      if (cmd_valid) begin
        ctl.load = 1'b1;
        case (ccdseq_pkg::kind_t'(cmd_kind))
          ccdseq_pkg::KIND_DIGITIZE: begin
            state_next = ccdseq_pkg::S_D247;
          end
          ccdseq_pkg::KIND_LINE: begin
            ctl.cnt_op    = ccdseq_pkg::CNT_LOAD;
            ctl.cnt_value = ccdseq_pkg::CNT_LINE;
            state_next    = ccdseq_pkg::S_LINE;
          end
          ccdseq_pkg::KIND_FAST: begin
            state_next = ccdseq_pkg::S_F7;
          end
          default: begin
            state_next = ccdseq_pkg::S_CTL;
          end
        endcase
      end
    end else if (stat.adv) begin
      ctl.emit = 1'b1;
      case (state)
        ccdseq_pkg::S_D247: begin
          ctl.sel       = ccdseq_pkg::BS_247;
          ctl.cnt_op    = ccdseq_pkg::CNT_LOAD;
          ctl.cnt_value = ccdseq_pkg::CNT_PRE;
          state_next    = ccdseq_pkg::S_D255;
        end
        ccdseq_pkg::S_D255: begin
          ctl.sel = ccdseq_pkg::BS_255;
          if (stat.cnt_last) begin
            state_next = ccdseq_pkg::S_D239;
          end else begin
            ctl.cnt_op = ccdseq_pkg::CNT_DEC;
          end
        end
        ccdseq_pkg::S_D239: begin
          ctl.sel = ccdseq_pkg::BS_239;
          if (stat.bin_zero) begin
            ctl.cnt_op    = ccdseq_pkg::CNT_LOAD;
            ctl.cnt_value = ccdseq_pkg::CNT_TAIL;
            state_next    = ccdseq_pkg::S_D251;
          end else begin
            ctl.cnt_op = ccdseq_pkg::CNT_LOAD_BIN;
            state_next = ccdseq_pkg::S_DBHI;
          end
        end
        ccdseq_pkg::S_DBHI: begin
          ctl.sel    = ccdseq_pkg::BS_255;
          state_next = ccdseq_pkg::S_DBLO;
        end
        ccdseq_pkg::S_DBLO: begin
          ctl.sel = ccdseq_pkg::BS_251;
          if (stat.cnt_last) begin
            ctl.cnt_op    = ccdseq_pkg::CNT_LOAD;
            ctl.cnt_value = ccdseq_pkg::CNT_TAIL;
            state_next    = ccdseq_pkg::S_D251;
          end else begin
            ctl.cnt_op = ccdseq_pkg::CNT_DEC;
            state_next = ccdseq_pkg::S_DBHI;
          end
        end
        ccdseq_pkg::S_D251: begin
          ctl.sel = ccdseq_pkg::BS_251;
          if (stat.cnt_last) begin
            ctl.cnt_op    = ccdseq_pkg::CNT_LOAD;
            ctl.cnt_value = ccdseq_pkg::CNT_CLAMP;
            state_next    = ccdseq_pkg::S_D219;
          end else begin
            ctl.cnt_op = ccdseq_pkg::CNT_DEC;
          end
        end
        ccdseq_pkg::S_D219: begin
          ctl.sel = ccdseq_pkg::BS_219;
          if (stat.cnt_last) begin
            state_next = ccdseq_pkg::S_D91;
          end else begin
            ctl.cnt_op = ccdseq_pkg::CNT_DEC;
          end
        end
        ccdseq_pkg::S_D91: begin
          ctl.sel    = ccdseq_pkg::BS_91;
          state_next = ccdseq_pkg::S_D155;
        end
        ccdseq_pkg::S_D155: begin
          ctl.sel    = ccdseq_pkg::BS_155;
          state_next = ccdseq_pkg::S_D27;
        end
        ccdseq_pkg::S_D27: begin
          ctl.sel    = ccdseq_pkg::BS_27;
          ctl.last   = 1'b1;
          ctl.pix    = 1'b1;
          state_next = ccdseq_pkg::S_IDLE;
        end
        ccdseq_pkg::S_LINE: begin
          ctl.sel = ccdseq_pkg::BS_LINE;
          if (stat.cnt_last) begin
            ctl.last   = 1'b1;
            state_next = ccdseq_pkg::S_IDLE;
          end else begin
            ctl.cnt_op = ccdseq_pkg::CNT_DEC;
          end
        end
        ccdseq_pkg::S_F7: begin
          ctl.sel    = ccdseq_pkg::BS_F7;
          state_next = ccdseq_pkg::S_FF;
        end
        ccdseq_pkg::S_FF: begin
          ctl.sel    = ccdseq_pkg::BS_255;
          state_next = ccdseq_pkg::S_FB;
        end
        ccdseq_pkg::S_FB: begin
          ctl.sel    = ccdseq_pkg::BS_251;
          ctl.last   = 1'b1;
          state_next = ccdseq_pkg::S_IDLE;
        end
        default: begin
          ctl.sel    = ccdseq_pkg::BS_CTL;
          ctl.last   = 1'b1;
          state_next = ccdseq_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/ccdseq_dp.sv */
// Request capture, counter, binning register and result register of the sequencer
module ccdseq_dp #(
  parameter int MAX_BINNING = ccdseq_pkg::MAX_BINNING_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [ccdseq_pkg::BIN_W-1:0] cfg_data,
  input  ccdseq_pkg::ctl_t             ctl,
  output ccdseq_pkg::stat_t            stat,
  ccdseq_cmd_if.sink                   cmd,
  ccdseq_res_if.source                 res
);

  localparam logic [ccdseq_pkg::BIN_W-1:0] MaxBin = ccdseq_pkg::BIN_W'(MAX_BINNING);

  logic [ccdseq_pkg::BIN_W-1:0] binning;
  logic [ccdseq_pkg::BIN_W-1:0] bin_eff;
  logic [ccdseq_pkg::CNT_W-1:0] cnt;
  logic [15:0]                  sample;
  logic [7:0]                   ctl_value;
  logic                         eor;
  logic [15:0]                  flipped;
  logic [ccdseq_pkg::PIX_W-1:0] pix_sat;
  logic [7:0]                   byte_sel;
  logic                         res_valid;

  assign bin_eff = (binning > MaxBin) ? MaxBin : binning;

  assign stat.adv      = !res_valid || res.ready;
  assign stat.cnt_last = (cnt == ccdseq_pkg::CNT_ONE);
  assign stat.bin_zero = (bin_eff == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      binning <= ccdseq_pkg::BINNING_RESET;
    end else if (cfg_we) begin
      binning <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sample    <= {cmd.adc_status_d[7:4], cmd.adc_status_c[7:4],
                    cmd.adc_status_b[7:4], cmd.adc_status_a[7:4]};
      ctl_value <= cmd.control_value;
      eor       <= cmd.end_of_row;
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.cnt_op)
      ccdseq_pkg::CNT_DEC:      cnt <= cnt - ccdseq_pkg::CNT_ONE;
      ccdseq_pkg::CNT_LOAD:     cnt <= ctl.cnt_value;
      ccdseq_pkg::CNT_LOAD_BIN: cnt <= ccdseq_pkg::CNT_W'(bin_eff);
      default:                  cnt <= cnt;
    endcase
  end

  assign flipped = sample ^ ccdseq_pkg::PIX_FLIP;
  assign pix_sat = flipped[15] ? ccdseq_pkg::PIX_MAX : flipped[ccdseq_pkg::PIX_W-1:0];

  always_comb begin
    case (ctl.sel)
      ccdseq_pkg::BS_247: byte_sel = ccdseq_pkg::BYTE_247;
      ccdseq_pkg::BS_255: byte_sel = ccdseq_pkg::BYTE_255;
      ccdseq_pkg::BS_239: byte_sel = ccdseq_pkg::BYTE_239;
      ccdseq_pkg::BS_251: byte_sel = ccdseq_pkg::BYTE_251;
      ccdseq_pkg::BS_219: byte_sel = ccdseq_pkg::BYTE_219;
      ccdseq_pkg::BS_91:  byte_sel = ccdseq_pkg::BYTE_91;
      ccdseq_pkg::BS_155: byte_sel = ccdseq_pkg::BYTE_155;
      ccdseq_pkg::BS_27:  byte_sel = ccdseq_pkg::BYTE_27;
      ccdseq_pkg::BS_F7:  byte_sel = ccdseq_pkg::BYTE_247F;
      ccdseq_pkg::BS_CTL: byte_sel = ctl_value ^ ccdseq_pkg::CTL_FLIP;
      ccdseq_pkg::BS_LINE: begin
        if (cnt > ccdseq_pkg::LINE_B1) begin
          byte_sel = ccdseq_pkg::BYTE_251;
        end else if (cnt > ccdseq_pkg::LINE_B2) begin
          byte_sel = ccdseq_pkg::BYTE_250;
        end else if (cnt > ccdseq_pkg::LINE_B3) begin
          byte_sel = ccdseq_pkg::BYTE_249;
        end else if (cnt > ccdseq_pkg::LINE_B4) begin
          byte_sel = ccdseq_pkg::BYTE_250;
        end else begin
          byte_sel = ccdseq_pkg::BYTE_251;
        end
      end
      default: byte_sel = ccdseq_pkg::BYTE_255;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (stat.adv) begin
      res_valid <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      res.drive_byte      <= byte_sel;
      res.to_control_port <= (ctl.sel == ccdseq_pkg::BS_CTL);
      res.pixel_valid     <= ctl.pix;
      res.pixel_value     <= ctl.pix ? pix_sat : '0;
      res.row_done        <= ctl.last & eor;
      res.last            <= ctl.last;
    end
  end

  assign res.valid = res_valid;

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the CCD clock sequencer: directed table, random phases, scoreboard
module testbench;

  localparam int MAX_PAIRS   = ccdseq_pkg::MAX_BINNING_DEF;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_TAIL  = 64;
  localparam int PHASE_ITEMS = 42;
  localparam int N_DIRECTED  = 23;

  typedef struct packed {
    ccdseq_pkg::kind_t kind;
    logic [7:0]        adc_status_a;
    logic [7:0]        adc_status_b;
    logic [7:0]        adc_status_c;
    logic [7:0]        adc_status_d;
    logic [7:0]        control_value;
    logic              end_of_row;
  } seq_req_t;

  typedef struct packed {
    logic [7:0]                   drive_byte;
    logic                         to_control_port;
    logic                         pixel_valid;
    logic [ccdseq_pkg::PIX_W-1:0] pixel_value;
    logic                         row_done;
    logic                         last;
  } drive_res_t;

  typedef struct packed {
    logic                         typed;
    logic [7:0]                   fin_byte;
    logic [ccdseq_pkg::PIX_W-1:0] fin_pix;
  } typed_final_t;

  typedef struct packed {
    logic                         set_bin;
    logic [ccdseq_pkg::BIN_W-1:0] bin;
    seq_req_t                     req;
    typed_final_t                 fin;
  } dir_row_t;

  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{1'b0, 5'd0,  '{ccdseq_pkg::KIND_DIGITIZE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
      '{1'b1, 8'd27, 15'd32767}},
    '{1'b0, 5'd0,  '{ccdseq_pkg::KIND_DIGITIZE, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 1'b1},
      '{1'b1, 8'd27, 15'd30583}},
    '{1'b0, 5'd0,  '{ccdseq_pkg::KIND_DIGITIZE, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00, 1'b0},
      '{1'b1, 8'd27, 15'd0}},
    '{1'b0, 5'd0,  '{ccdseq_pkg::KIND_DIGITIZE, 8'h70, 8'h70, 8'h70, 8'hf0, 8'h00, 1'b0},
      '{1'b1, 8'd27, 15'd32767}},
    '{1'b0, 5'd0,  '{ccdseq_pkg::KIND_DIGITIZE, 8'h80, 8'h80, 8'h80, 8'h00, 8'h00, 1'b1},
      '{1'b1, 8'd27, 15'd32767}},
    '{1'b0, 5'd0,  '{ccdseq_pkg::KIND_DIGITIZE, 8'h80, 8'h80, 8'h80, 8'hf0, 8'h00, 1'b0},
      '{1'b1, 8'd27, 15'd28672}},
    '{1'b0, 5'd0,  '{ccdseq_pkg::KIND_DIGITIZE, 8'h0f, 8'h0f, 8'h0f, 8'h0f, 8'h00, 1'b0},
      '{1'b1, 8'd27, 15'd32767}},
    '{1'b0, 5'd0,  '{ccdseq_pkg::KIND_DIGITIZE, 8'hf0, 8'hf0, 8'hf0, 8'h80, 8'h00, 1'b1},
      '{1'b1, 8'd27, 15'd1911}},
    '{1'b0, 5'd0,  '{ccdseq_pkg::KIND_LINE,     8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
      '{1'b1, 8'hfb, 15'd0}},
    '{1'b0, 5'd0,  '{ccdseq_pkg::KIND_LINE,     8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1},
      '{1'b1, 8'hfb, 15'd0}},
    '{1'b0, 5'd0,  '{ccdseq_pkg::KIND_FAST,     8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
      '{1'b1, 8'hfb, 15'd0}},
    '{1'b0, 5'd0,  '{ccdseq_pkg::KIND_FAST,     8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1},
      '{1'b1, 8'hfb, 15'd0}},
    '{1'b0, 5'd0,  '{ccdseq_pkg::KIND_CONTROL,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
      '{1'b1, 8'h05, 15'd0}},
    '{1'b0, 5'd0,  '{ccdseq_pkg::KIND_CONTROL,  8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 1'b1},
      '{1'b1, 8'hfa, 15'd0}},
    '{1'b0, 5'd0,  '{ccdseq_pkg::KIND_CONTROL,  8'hff, 8'hff, 8'hff, 8'hff, 8'h5a, 1'b0},
      '{1'b1, 8'h5f, 15'd0}},
    '{1'b0, 5'd0,  '{ccdseq_pkg::KIND_CONTROL,  8'h00, 8'h00, 8'h00, 8'h00, 8'ha5, 1'b1},
      '{1'b1, 8'ha0, 15'd0}},
    '{1'b1, 5'd0,  '{ccdseq_pkg::KIND_DIGITIZE, 8'h12, 8'h34, 8'h56, 8'h78, 8'h00, 1'b0},
      '{1'b0, 8'd0,  15'd0}},
    '{1'b1, 5'd16, '{ccdseq_pkg::KIND_DIGITIZE, 8'h9c, 8'h3e, 8'h71, 8'hd4, 8'h00, 1'b1},
      '{1'b0, 8'd0,  15'd0}},
    '{1'b1, 5'd17, '{ccdseq_pkg::KIND_DIGITIZE, 8'h9c, 8'h3e, 8'h71, 8'hd4, 8'h00, 1'b0},
      '{1'b0, 8'd0,  15'd0}},
    '{1'b1, 5'd31, '{ccdseq_pkg::KIND_DIGITIZE, 8'hc3, 8'he9, 8'h17, 8'h4d, 8'h00, 1'b1},
      '{1'b0, 8'd0,  15'd0}},
    '{1'b0, 5'd0,  '{ccdseq_pkg::KIND_LINE,     8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1},
      '{1'b0, 8'd0,  15'd0}},
    '{1'b1, 5'd2,  '{ccdseq_pkg::KIND_FAST,     8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
      '{1'b0, 8'd0,  15'd0}},
    '{1'b0, 5'd0,  '{ccdseq_pkg::KIND_DIGITIZE, 8'h55, 8'haa, 8'h55, 8'haa, 8'h00, 1'b1},
      '{1'b0, 8'd0,  15'd0}}
  };

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         cfg_we;
  logic [ccdseq_pkg::BIN_W-1:0] cfg_data;

  ccdseq_cmd_if cmd_ch ();
  ccdseq_res_if res_ch ();

  ccd_clock_sequencer #(.MAX_BINNING(MAX_PAIRS)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd_ch.sink),
    .res      (res_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  drive_res_t                   expected_drive [$];
  typed_final_t                 typed_finals [$];
  logic [ccdseq_pkg::BIN_W-1:0] bin_setting = ccdseq_pkg::BINNING_RESET;
  int                           mismatches = 0;
  int                           burst_left = 4;

  function automatic void push_drive(logic [7:0] value, logic ctl);
    drive_res_t r;
    r = '0;
    r.drive_byte = value;
    r.to_control_port = ctl;
    expected_drive.push_back(r);
  endfunction

  function automatic void predict_drive_run(seq_req_t q, typed_final_t tf);
    int          pairs;
    int          fin;
    logic [15:0] word;
    pairs = (bin_setting > MAX_PAIRS) ? MAX_PAIRS : int'(bin_setting);
    case (q.kind)
      ccdseq_pkg::KIND_DIGITIZE: begin
        push_drive(ccdseq_pkg::BYTE_247, 1'b0);
        repeat (5) push_drive(ccdseq_pkg::BYTE_255, 1'b0);
        push_drive(ccdseq_pkg::BYTE_239, 1'b0);
        repeat (pairs) begin
          push_drive(ccdseq_pkg::BYTE_255, 1'b0);
          push_drive(ccdseq_pkg::BYTE_251, 1'b0);
        end
        repeat (4) push_drive(ccdseq_pkg::BYTE_251, 1'b0);
        repeat (6) push_drive(ccdseq_pkg::BYTE_219, 1'b0);
        push_drive(ccdseq_pkg::BYTE_91, 1'b0);
        push_drive(ccdseq_pkg::BYTE_155, 1'b0);
        push_drive(ccdseq_pkg::BYTE_27, 1'b0);
      end
      ccdseq_pkg::KIND_LINE: begin
        repeat (8) push_drive(ccdseq_pkg::BYTE_251, 1'b0);
        repeat (8) push_drive(ccdseq_pkg::BYTE_250, 1'b0);
        repeat (8) push_drive(ccdseq_pkg::BYTE_249, 1'b0);
        repeat (8) push_drive(ccdseq_pkg::BYTE_250, 1'b0);
        repeat (8) push_drive(ccdseq_pkg::BYTE_251, 1'b0);
      end
      ccdseq_pkg::KIND_FAST: begin
        push_drive(ccdseq_pkg::BYTE_247F, 1'b0);
        push_drive(ccdseq_pkg::BYTE_255, 1'b0);
        push_drive(ccdseq_pkg::BYTE_251, 1'b0);
      end
      default: push_drive(q.control_value ^ ccdseq_pkg::CTL_FLIP, 1'b1);
    endcase
    fin = expected_drive.size() - 1;
    if (q.kind == ccdseq_pkg::KIND_DIGITIZE) begin
      word = {q.adc_status_d[7:4], q.adc_status_c[7:4], q.adc_status_b[7:4],
              q.adc_status_a[7:4]} ^ ccdseq_pkg::PIX_FLIP;
      expected_drive[fin].pixel_valid = 1'b1;
      expected_drive[fin].pixel_value = (word > 16'(ccdseq_pkg::PIX_MAX)) ?
                                        ccdseq_pkg::PIX_MAX :
                                        word[ccdseq_pkg::PIX_W-1:0];
    end
    if (tf.typed) begin
      expected_drive[fin].drive_byte = tf.fin_byte;
      expected_drive[fin].pixel_value = tf.fin_pix;
    end
    expected_drive[fin].row_done = q.end_of_row;
    expected_drive[fin].last = 1'b1;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    seq_req_t     q;
    typed_final_t tf;
    drive_res_t   e;
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        q.kind = ccdseq_pkg::kind_t'(cmd_ch.kind);
        q.adc_status_a = cmd_ch.adc_status_a;
        q.adc_status_b = cmd_ch.adc_status_b;
        q.adc_status_c = cmd_ch.adc_status_c;
        q.adc_status_d = cmd_ch.adc_status_d;
        q.control_value = cmd_ch.control_value;
        q.end_of_row = cmd_ch.end_of_row;
        tf = (typed_finals.size() != 0) ? typed_finals.pop_front() : '0;
        predict_drive_run(q, tf);
      end
      if (res_ch.valid && res_ch.ready) begin
        if (expected_drive.size() == 0) begin
          $error("unexpected result: drive_byte %0d", res_ch.drive_byte);
          mismatches++;
        end else begin
          e = expected_drive.pop_front();
          check_field("drive_byte", e.drive_byte, res_ch.drive_byte);
          check_field("to_control_port", e.to_control_port, res_ch.to_control_port);
          check_field("pixel_valid", e.pixel_valid, res_ch.pixel_valid);
          check_field("pixel_value", e.pixel_value, res_ch.pixel_value);
          check_field("row_done", e.row_done, res_ch.row_done);
          check_field("last", e.last, res_ch.last);
        end
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int mode;
    int seg;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    repeat (200) begin
      res_ch.ready <= 1'($urandom_range(0, 1));
      @(posedge clk);
    end
    res_ch.ready <= 1'b0;
    repeat (250) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      seg = $urandom_range(16, 160);
      for (int i = 0; i < seg; i++) begin
        case (mode)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= ($urandom_range(0, 3) != 0);
          2: res_ch.ready <= ($urandom_range(0, 3) == 0);
          default: res_ch.ready <= (i % 3 == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic offer(seq_req_t q, typed_final_t tf);
    typed_finals.push_back(tf);
    cmd_ch.valid <= 1'b1;
    cmd_ch.kind <= q.kind;
    cmd_ch.adc_status_a <= q.adc_status_a;
    cmd_ch.adc_status_b <= q.adc_status_b;
    cmd_ch.adc_status_c <= q.adc_status_c;
    cmd_ch.adc_status_d <= q.adc_status_d;
    cmd_ch.control_value <= q.control_value;
    cmd_ch.end_of_row <= q.end_of_row;
    do @(posedge clk); while (!cmd_ch.ready);
    burst_left--;
    if (burst_left <= 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 8);
    end
  endtask

  task automatic drain_runs();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_drive.size() != 0) @(posedge clk);
  endtask

  task automatic write_binning(logic [ccdseq_pkg::BIN_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    bin_setting = value;
  endtask

  function automatic logic [7:0] status_byte();
    logic [3:0] hi;
    case ($urandom_range(0, 5))
      0: hi = 4'h0;
      1: hi = 4'h7;
      2: hi = 4'h8;
      3: hi = 4'hf;
      default: hi = 4'($urandom_range(0, 15));
    endcase
    return {hi, 4'($urandom_range(0, 15))};
  endfunction

  initial begin
    logic [ccdseq_pkg::BIN_W-1:0] phase_bins [6];
    seq_req_t                     q;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.kind <= ccdseq_pkg::KIND_DIGITIZE;
    cmd_ch.adc_status_a <= '0;
    cmd_ch.adc_status_b <= '0;
    cmd_ch.adc_status_c <= '0;
    cmd_ch.adc_status_d <= '0;
    cmd_ch.control_value <= '0;
    cmd_ch.end_of_row <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].set_bin) begin
        drain_runs();
        write_binning(DIRECTED[i].bin);
      end
      offer(DIRECTED[i].req, DIRECTED[i].fin);
    end

    phase_bins = '{5'd31, 5'd0, 5'd16, 5'd17,
                   ccdseq_pkg::BIN_W'($urandom_range(0, 31)), 5'd1};
    foreach (phase_bins[p]) begin
      drain_runs();
      write_binning(phase_bins[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        q.kind = ccdseq_pkg::kind_t'($urandom_range(0, 3));
        q.adc_status_a = status_byte();
        q.adc_status_b = status_byte();
        q.adc_status_c = status_byte();
        q.adc_status_d = status_byte();
        q.control_value = 8'($urandom_range(0, 255));
        q.end_of_row = 1'($urandom_range(0, 1));
        offer(q, '0);
        if ($urandom_range(0, 49) == 0)
          drain_runs();
      end
    end

    drain_runs();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/ccdseq_pkg.sv
src/ccdseq_cmd_if.sv
src/ccdseq_res_if.sv
src/ccdseq_ctrl.sv
src/ccdseq_dp.sv
src/ccd_clock_sequencer.sv
bench/testbench.sv
